[rtl/core/adcss_pkg.sv]
// shared constants, codes and types of the adc scan sequencer
`default_nettype none

package adcss_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    localparam int FUNC_W   = 2;
    localparam int CHAN_W   = 8;
    localparam int SET_W    = 8;
    localparam int SMP_W    = 16;
    localparam int OUT_CH_W = 4;

    // request function codes
    localparam logic [FUNC_W-1:0] FN_ENABLE = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK   = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DONE   = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // access bundle from the sequencer to the list and sample stores
    typedef struct packed {
        logic             rd_en;
        logic [CH_W-1:0]  list_rd_addr;
        logic [CH_W-1:0]  smp_rd_addr;
        logic             list_we;
        logic [CH_W-1:0]  list_wr_addr;
        logic [CH_W-1:0]  list_wr_data;
        logic             smp_we;
        logic             smp_clr;
        logic [CH_W-1:0]  smp_wr_addr;
        logic [SMP_W-1:0] smp_wr_data;
    } t_mem_req;

    typedef struct packed {
        logic                error;
        logic                start_valid;
        logic [OUT_CH_W-1:0] start_channel;
        logic                config_valid;
        logic [OUT_CH_W-1:0] config_channel;
        logic [SET_W-1:0]    config_setting;
        logic [SMP_W-1:0]    read_value;
        logic                busy_res;
    } t_result;

endpackage

`default_nettype wire

[rtl/core/adcss_req_if.sv]
// request channel of the adc scan sequencer
`default_nettype none

interface adcss_req_if;
    logic                         valid;
    logic                         ready;
    logic [adcss_pkg::FUNC_W-1:0] func;
    logic [adcss_pkg::CHAN_W-1:0] channel;
    logic [adcss_pkg::SET_W-1:0]  setting;
    logic [adcss_pkg::SMP_W-1:0]  sample;

    modport source (output valid, func, channel, setting, sample, input ready);
    modport sink   (input valid, func, channel, setting, sample, output ready);
endinterface

`default_nettype wire

[rtl/core/adcss_rsp_if.sv]
// result channel of the adc scan sequencer
`default_nettype none

interface adcss_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           error;
    logic                           start_valid;
    logic [adcss_pkg::OUT_CH_W-1:0] start_channel;
    logic                           config_valid;
    logic [adcss_pkg::OUT_CH_W-1:0] config_channel;
    logic [adcss_pkg::SET_W-1:0]    config_setting;
    logic [adcss_pkg::SMP_W-1:0]    read_value;
    logic                           busy_res;

    modport source (output valid, error, start_valid, start_channel, config_valid,
                    config_channel, config_setting, read_value, busy_res,
                    input ready);
    modport sink   (input valid, error, start_valid, start_channel, config_valid,
                    config_channel, config_setting, read_value, busy_res,
                    output ready);
endinterface

`default_nettype wire

[rtl/core/adcss_store.sv]
// scan list memory and per-channel sample memory with valid bits
`default_nettype none

module adcss_store (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire adcss_pkg::t_mem_req          i_mem,
    output logic [adcss_pkg::CH_W-1:0]        o_list_rd_data,
    output logic [adcss_pkg::SMP_W-1:0]       o_smp_rd_data
);
    import adcss_pkg::*;

    logic [CH_W-1:0]         r_list_mem [NUM_CHANNELS];
    logic [SMP_W-1:0]        r_smp_mem  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_smp_ok;
    logic [CH_W-1:0]         r_list_rd;
    logic [SMP_W-1:0]        r_smp_rd;
    logic                    r_smp_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_mem.list_we) begin
            r_list_mem[i_mem.list_wr_addr] <= i_mem.list_wr_data;
        end
        if (i_mem.smp_we) begin
            r_smp_mem[i_mem.smp_wr_addr] <= i_mem.smp_wr_data;
        end
        if (i_mem.rd_en) begin
            r_list_rd <= r_list_mem[i_mem.list_rd_addr];
            r_smp_rd  <= r_smp_mem[i_mem.smp_rd_addr];
        end
    end

    // a channel never written since reset or since it was listed reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_ok    <= '0;
            r_smp_rd_ok <= 1'b0;
        end else begin
            if (i_mem.smp_we) begin
                r_smp_ok[i_mem.smp_wr_addr] <= 1'b1;
            end else if (i_mem.smp_clr) begin
                r_smp_ok[i_mem.smp_wr_addr] <= 1'b0;
            end
            if (i_mem.rd_en) begin
                r_smp_rd_ok <= r_smp_ok[i_mem.smp_rd_addr];
            end
        end
    end

    assign o_list_rd_data = r_list_rd;
    assign o_smp_rd_data  = r_smp_rd_ok ? r_smp_rd : '0;

endmodule

`default_nettype wire

[rtl/core/adc_scan_sequencer_top.sv]
// adc scan sequencer: channel list, scan control and sample read-back
//
//  port    dir  modport  moves
//  i_req   in   sink     func, channel, setting, sample
//  o_rsp   out  source   one result per request
//
// the accept edge of a request launches the list and sample memory reads, and
// the execute state then uses the read data and writes back.
// reset leaves the list empty, all samples reading zero and no scan running.
// a result waiting in the output register does not block the next accept;
// the execute cycle holds until that register is free.
`default_nettype none

module adc_scan_sequencer_top (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    adcss_req_if.sink   i_req,
    adcss_rsp_if.source o_rsp
);
    import adcss_pkg::*;

    t_state                  r_state, n_state;
    logic [FUNC_W-1:0]       r_func;
    logic [CHAN_W-1:0]       r_ch;
    logic [SET_W-1:0]        r_setting;
    logic [SMP_W-1:0]        r_smp;
    logic [NUM_CHANNELS-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]        r_list_count, n_list_count;
    logic [CNT_W-1:0]        r_scan_index, n_scan_index;
    logic [CH_W-1:0]         r_active, n_active;
    logic                    r_running, n_running;
    t_result                 r_out, n_out;
    logic                    r_out_valid, n_out_valid;

    t_mem_req                mem;
    logic [CH_W-1:0]         list_rd_data;
    logic [SMP_W-1:0]        smp_rd_data;
    logic                    accept;
    logic                    fire;
    logic                    in_range;
    logic [CH_W-1:0]         chi;
    logic [CNT_W-1:0]        next_idx;
    logic                    smp_fwd;
    logic                    smp_zero;

    adcss_store u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mem          (mem),
        .o_list_rd_data (list_rd_data),
        .o_smp_rd_data  (smp_rd_data)
    );

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign fire        = (r_state == ST_EXEC) && (!r_out_valid || o_rsp.ready);
    assign in_range    = {1'b0, r_ch} < (CHAN_W + 1)'(NUM_CHANNELS);
    assign chi         = r_ch[CH_W-1:0];
    assign next_idx    = r_scan_index + CNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func    <= i_req.func;
            r_ch      <= i_req.channel;
            r_setting <= i_req.setting;
            r_smp     <= i_req.sample;
        end
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mask       <= '0;
            r_list_count <= '0;
            r_scan_index <= '0;
            r_active     <= '0;
            r_running    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mask       <= n_mask;
            r_list_count <= n_list_count;
            r_scan_index <= n_scan_index;
            r_active     <= n_active;
            r_running    <= n_running;
            r_out_valid  <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_mask       = r_mask;
        n_list_count = r_list_count;
        n_scan_index = r_scan_index;
        n_active     = r_active;
        n_running    = r_running;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        smp_fwd      = 1'b0;
        smp_zero     = 1'b0;

        mem              = '0;
        mem.rd_en        = accept;
        // tick needs the list head, done needs the next list entry
        mem.list_rd_addr = (i_req.func == FN_DONE) ? CH_W'(next_idx) : '0;
        mem.smp_rd_addr  = CH_W'(i_req.channel);
        mem.smp_wr_data  = r_smp;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    case (r_func)
                        FN_ENABLE: begin
                            if (!in_range) begin
                                n_out.error = 1'b1;
                            end else if (r_mask[chi]) begin
                                n_out.config_valid   = 1'b1;
                                n_out.config_channel = OUT_CH_W'(chi);
                                n_out.config_setting = r_setting;
                            end else if (r_list_count < CNT_W'(NUM_CHANNELS)) begin
                                mem.list_we          = 1'b1;
                                mem.list_wr_addr     = CH_W'(r_list_count);
                                mem.list_wr_data     = chi;
                                mem.smp_clr          = 1'b1;
                                mem.smp_wr_addr      = chi;
                                n_list_count         = r_list_count + CNT_W'(1);
                                n_mask[chi]          = 1'b1;
                                smp_zero             = 1'b1;
                                n_out.config_valid   = 1'b1;
                                n_out.config_channel = OUT_CH_W'(chi);
                                n_out.config_setting = r_setting;
                            end
                        end
                        FN_TICK: begin
                            if (r_list_count != '0 && !r_running) begin
                                n_scan_index        = '0;
                                n_active            = list_rd_data;
                                n_running           = 1'b1;
                                n_out.start_valid   = 1'b1;
                                n_out.start_channel = OUT_CH_W'(list_rd_data);
                            end
                        end
                        FN_DONE: begin
                            if (r_running) begin
                                mem.smp_we      = 1'b1;
                                mem.smp_wr_addr = r_active;
                                smp_fwd         = (r_active == chi);
                                if (next_idx < r_list_count) begin
                                    n_scan_index        = next_idx;
                                    n_active            = list_rd_data;
                                    n_out.start_valid   = 1'b1;
                                    n_out.start_channel = OUT_CH_W'(list_rd_data);
                                end else begin
                                    n_scan_index = '0;
                                    n_running    = 1'b0;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    // read-back sees this request's own write to the channel
                    if (!in_range || smp_zero) begin
                        n_out.read_value = '0;
                    end else if (smp_fwd) begin
                        n_out.read_value = r_smp;
                    end else begin
                        n_out.read_value = smp_rd_data;
                    end
                    n_out.busy_res = n_running;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.error          = r_out.error;
    assign o_rsp.start_valid    = r_out.start_valid;
    assign o_rsp.start_channel  = r_out.start_channel;
    assign o_rsp.config_valid   = r_out.config_valid;
    assign o_rsp.config_channel = r_out.config_channel;
    assign o_rsp.config_setting = r_out.config_setting;
    assign o_rsp.read_value     = r_out.read_value;
    assign o_rsp.busy_res       = r_out.busy_res;

    a_count_is_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_mask) == int'(r_list_count))
        else $error("list count does not match enabled channels");

    a_index_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_scan_index < r_list_count))
        else $error("scan index beyond list while running");

    a_idle_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_running |-> (r_scan_index == '0))
        else $error("scan index not cleared while idle");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_busy_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> (r_out.busy_res == r_running))
        else $error("reported busy differs from scan state");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking testbench of the adc scan sequencer: predicted results against the result channel
`default_nettype none

module tb_top;
    import adcss_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 100000;
    localparam int RANDOM_REQUESTS = 700;

    // predicts each result from accepted requests and holds the ones still due
    class scan_result_board;
        t_result                     pending_results[$];
        logic [CH_W-1:0]             scan_order[NUM_CHANNELS];
        logic [NUM_CHANNELS-1:0]     listed;
        logic [SMP_W-1:0]            samples[NUM_CHANNELS];
        logic [CNT_W-1:0]            listed_count;
        logic [CNT_W-1:0]            scan_pos;
        logic [CH_W-1:0]             converting;
        bit                          scanning;
        int                          failures;

        function new();
            listed       = '0;
            listed_count = '0;
            scan_pos     = '0;
            converting   = '0;
            scanning     = 1'b0;
            failures     = 0;
            foreach (samples[i]) samples[i] = '0;
            foreach (scan_order[i]) scan_order[i] = '0;
        endfunction

        function void note_request(logic [FUNC_W-1:0] fn, logic [CHAN_W-1:0] ch,
                                   logic [SET_W-1:0] setting, logic [SMP_W-1:0] smp);
            t_result r;
            r = '0;
            case (fn)
                FN_ENABLE: begin
                    if (ch >= NUM_CHANNELS) begin
                        r.error = 1'b1;
                    end else if (listed[ch[CH_W-1:0]]) begin
                        r.config_valid   = 1'b1;
                        r.config_channel = ch[CH_W-1:0];
                        r.config_setting = setting;
                    end else if (listed_count < NUM_CHANNELS) begin
                        samples[ch[CH_W-1:0]]                = '0;
                        scan_order[listed_count[CH_W-1:0]]   = ch[CH_W-1:0];
                        listed_count                         = listed_count + 1'b1;
                        listed[ch[CH_W-1:0]]                 = 1'b1;
                        r.config_valid                       = 1'b1;
                        r.config_channel                     = ch[CH_W-1:0];
                        r.config_setting                     = setting;
                    end
                end
                FN_TICK: begin
                    if (listed_count != 0 && !scanning) begin
                        scan_pos        = '0;
                        converting      = scan_order[0];
                        scanning        = 1'b1;
                        r.start_valid   = 1'b1;
                        r.start_channel = converting;
                    end
                end
                FN_DONE: begin
                    if (scanning) begin
                        samples[converting] = smp;
                        scan_pos = scan_pos + 1'b1;
                        if (scan_pos < listed_count && scan_pos < NUM_CHANNELS) begin
                            converting      = scan_order[scan_pos[CH_W-1:0]];
                            r.start_valid   = 1'b1;
                            r.start_channel = converting;
                        end else begin
                            scan_pos   = '0;
                            converting = scan_order[0];
                            scanning   = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
            r.read_value = (ch < NUM_CHANNELS) ? samples[ch[CH_W-1:0]] : '0;
            r.busy_res   = scanning;
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                failures++;
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                failures++;
                $display("%0t: result with none expected, actual %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            compare_field("error", want.error, got.error);
            compare_field("start_valid", want.start_valid, got.start_valid);
            compare_field("start_channel", want.start_channel, got.start_channel);
            compare_field("config_valid", want.config_valid, got.config_valid);
            compare_field("config_channel", want.config_channel, got.config_channel);
            compare_field("config_setting", want.config_setting, got.config_setting);
            compare_field("read_value", want.read_value, got.read_value);
            compare_field("busy_res", want.busy_res, got.busy_res);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycles = 0;
    int   tx_quiet = 0;
    int   rx_quiet = 0;

    scan_result_board sb = new();

    adcss_req_if req_if();
    adcss_rsp_if rsp_if();

    adc_scan_sequencer_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("adc_scan_sequencer_top verification failed");
            $finish;
        end
    end

    // wait before the next request or result, with runs of back-to-back traffic
    function automatic int draw_wait(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) quiet = $urandom_range(10, 40);
        return $urandom_range(0, 4);
    endfunction

    task automatic send_request(logic [FUNC_W-1:0] fn, logic [CHAN_W-1:0] ch,
                                logic [SET_W-1:0] setting, logic [SMP_W-1:0] smp);
        int gap;
        gap = draw_wait(tx_quiet);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= fn;
        req_if.channel <= ch;
        req_if.setting <= setting;
        req_if.sample  <= smp;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(fn, ch, setting, smp);
    endtask

    // drop valid so the last request is not taken twice, then wait for every result
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_results.size() != 0);
    endtask

    task automatic run_random(int count);
        int                sent;
        int                pick;
        logic [FUNC_W-1:0] fn;
        logic [CHAN_W-1:0] ch;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            // during a scan mostly finish conversions, while idle mostly enable and start
            if (sb.scanning) begin
                fn = (pick < 75) ? FN_DONE : (pick < 85) ? FN_ENABLE :
                     (pick < 95) ? FN_TICK : FN_UNUSED;
            end else begin
                fn = (pick < 40) ? FN_TICK : (pick < 75) ? FN_ENABLE :
                     (pick < 90) ? FN_DONE : FN_UNUSED;
            end
            ch = ($urandom_range(0, 99) < 85) ? CHAN_W'($urandom_range(0, NUM_CHANNELS - 1))
                                               : CHAN_W'($urandom_range(0, 255));
            send_request(fn, ch, SET_W'($urandom_range(0, 255)),
                         SMP_W'($urandom_range(0, 65535)));
            sent++;
            if (sent == count / 2) wait_drained();
        end
    endtask

    initial begin
        t_result got;
        int      stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = draw_wait(rx_quiet);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
            got = '{error: rsp_if.error, start_valid: rsp_if.start_valid,
                    start_channel: rsp_if.start_channel, config_valid: rsp_if.config_valid,
                    config_channel: rsp_if.config_channel,
                    config_setting: rsp_if.config_setting,
                    read_value: rsp_if.read_value, busy_res: rsp_if.busy_res};
            sb.check_result(got);
        end
    end

    initial begin
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.func    <= FN_ENABLE;
        req_if.channel <= '0;
        req_if.setting <= '0;
        req_if.sample  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty list, idle conversion done, unused code, out-of-range enables
        send_request(FN_TICK,   8'd0,   8'h00, 16'h0000);
        send_request(FN_DONE,   8'd255, 8'hff, 16'hffff);
        send_request(FN_UNUSED, 8'haa,  8'h55, 16'h1234);
        send_request(FN_ENABLE, 8'd255, 8'hff, 16'h0000);
        send_request(FN_ENABLE, 8'd16,  8'h12, 16'h0000);
        // list 15, 0, then reconfigure 15 without relisting
        send_request(FN_ENABLE, 8'd15,  8'hff, 16'h0000);
        send_request(FN_ENABLE, 8'd0,   8'h00, 16'hffff);
        send_request(FN_ENABLE, 8'd15,  8'h5a, 16'h0000);
        // scan, tick while running, enable appended mid scan
        send_request(FN_TICK,   8'd15,  8'h00, 16'h0000);
        send_request(FN_TICK,   8'd0,   8'h00, 16'h0000);
        send_request(FN_ENABLE, 8'd7,   8'ha5, 16'h0000);
        send_request(FN_DONE,   8'd15,  8'h00, 16'hffff);
        send_request(FN_DONE,   8'd0,   8'h00, 16'h8001);
        send_request(FN_DONE,   8'd7,   8'h00, 16'h7ffe);
        send_request(FN_DONE,   8'd7,   8'h00, 16'h0000);
        send_request(FN_UNUSED, 8'd15,  8'h00, 16'h0000);
        // second scan reads back every listed channel
        send_request(FN_TICK,   8'd200, 8'h00, 16'h0000);
        send_request(FN_DONE,   8'd15,  8'h00, 16'h0001);
        send_request(FN_DONE,   8'd0,   8'h00, 16'h0000);
        send_request(FN_DONE,   8'd7,   8'h00, 16'haaaa);
        send_request(FN_UNUSED, 8'd7,   8'h00, 16'h0000);
        wait_drained();

        run_random(RANDOM_REQUESTS);
        wait_drained();
        repeat (20) @(posedge i_clk);

        if (sb.failures == 0 && sb.pending_results.size() == 0) begin
            $display("adc_scan_sequencer_top verification clean");
        end else begin
            $display("adc_scan_sequencer_top verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/adcss_pkg.sv
rtl/core/adcss_req_if.sv
rtl/core/adcss_rsp_if.sv
rtl/core/adcss_store.sv
rtl/core/adc_scan_sequencer_top.sv
sim/tb_top.sv
